// ===== src/adpe_pkg.sv =====
// Package for the ARM data-processing execute block: codes, masks and the
// structs that pass between the register file, the execute logic and the top.
// No dependencies.
`default_nettype none

package adpe_pkg;

  // Payload widths of the stream ports
  localparam int unsigned INSTR_W = 32;
  localparam int unsigned OUT_W   = 80;

  // Instruction class masks
  localparam logic [31:0] MISC_MASK  = 32'h0D90_0000;
  localparam logic [31:0] MISC_MATCH = 32'h0100_0000;
  localparam logic [31:0] EXT_MASK   = 32'h0E00_0090;
  localparam logic [31:0] EXT_MATCH  = 32'h0000_0090;

  // Result status codes
  typedef enum logic [2:0] {
    ST_EXECUTED  = 3'd0,
    ST_COND_FAIL = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_UNIMPL    = 3'd3,
    ST_UNDEF_NV  = 3'd4
  } status_t;

  // Data-processing opcodes
  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } opcode_t;

  // Condition field codes
  typedef enum logic [3:0] {
    CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
    CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
    CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_t;

  // Barrel shifter types
  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_t;

  // Register file write port
  typedef struct packed {
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
  } rf_wr_t;

  // Operand values read for one instruction (r15 not substituted)
  typedef struct packed {
    logic [31:0] rn;
    logic [31:0] rm;
    logic [31:0] rs;
  } operands_t;

  // Result of one executed instruction
  typedef struct packed {
    status_t     status;
    logic        wrote;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [3:0]  flags;
    logic [31:0] next_pc;
  } exec_res_t;

endpackage

`default_nettype wire

// ===== src/adpe_regfile.sv =====
// Register file r0..r14 as two identical banks with registered reads, one
// valid bit per entry and a bypass for the write landing at the read edge.
// Depends on adpe_pkg.
`default_nettype none

module adpe_regfile (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [3:0]          raddr_n,
  input  wire logic [3:0]          raddr_m,
  input  wire logic [3:0]          raddr_s,
  input  wire adpe_pkg::rf_wr_t    wr,
  output adpe_pkg::operands_t      ops
);

  logic [31:0] mem_a [16];
  logic [31:0] mem_b [16];
  logic [15:0] valid;

  logic [31:0] raw_n, raw_m, raw_s, fwd_data;
  logic        vld_n, vld_m, vld_s;
  logic        fwd_n, fwd_m, fwd_s;

  // Write both banks, read Rn/Rm from bank A and Rs from bank B
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_a[wr.waddr] <= wr.wdata;
      mem_b[wr.waddr] <= wr.wdata;
    end
    if (rd_en) begin
      raw_n    <= mem_a[raddr_n];
      raw_m    <= mem_a[raddr_m];
      raw_s    <= mem_b[raddr_s];
      fwd_data <= wr.wdata;
    end
  end

  // Track written entries and capture bypass hits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_n <= 1'b0;
      vld_m <= 1'b0;
      vld_s <= 1'b0;
      fwd_n <= 1'b0;
      fwd_m <= 1'b0;
      fwd_s <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.waddr] <= 1'b1;
      end
      if (rd_en) begin
        vld_n <= valid[raddr_n];
        vld_m <= valid[raddr_m];
        vld_s <= valid[raddr_s];
        fwd_n <= wr.we && (wr.waddr == raddr_n);
        fwd_m <= wr.we && (wr.waddr == raddr_m);
        fwd_s <= wr.we && (wr.waddr == raddr_s);
      end
    end
  end

  // Unwritten entries read as zero
  assign ops.rn = fwd_n ? fwd_data : (vld_n ? raw_n : 32'd0);
  assign ops.rm = fwd_m ? fwd_data : (vld_m ? raw_m : 32'd0);
  assign ops.rs = fwd_s ? fwd_data : (vld_s ? raw_s : 32'd0);

endmodule

`default_nettype wire

// ===== src/adpe_exec.sv =====
// Execute logic for one instruction: decode, condition test, barrel shifter,
// ALU and flag update, all combinational.
// Depends on adpe_pkg.
`default_nettype none

module adpe_exec (
  input  wire logic [31:0]          instr,
  input  wire adpe_pkg::operands_t  ops,
  input  wire logic [31:0]          pc,
  input  wire logic [3:0]           flags,
  output adpe_pkg::exec_res_t       res
);

  // Miscellaneous-space keys that belong to ignored classes
  localparam logic [7:0]  MISC_IMM_MSR_A = 8'h32;
  localparam logic [7:0]  MISC_IMM_MSR_B = 8'h36;
  localparam logic [11:0] MISC_BX        = 12'h121;
  localparam logic [11:0] MISC_MRS_A     = 12'h100;
  localparam logic [11:0] MISC_MRS_B     = 12'h140;
  localparam logic [11:0] MISC_MSR_A     = 12'h120;
  localparam logic [11:0] MISC_MSR_B     = 12'h160;

  typedef enum logic [1:0] {
    K_LOGIC = 2'd0, K_SUB = 2'd1, K_ADD = 2'd2
  } kind_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  logic        fn, fz, fc, fv;
  logic        cond_ok;
  logic [31:0] pc8, rn_v, rm_v, rs_v;

  logic [4:0]  imm_rot;
  logic [31:0] imm_val;
  logic [7:0]  amt;
  logic [32:0] lsl_t, lsr_t, asr_t;
  logic [31:0] ror_v;
  logic [31:0] sh;
  logic        sc;

  adpe_pkg::opcode_t op;
  kind_t       kind;
  logic        write_rd, impl;
  logic [31:0] a, b, b_eff, lres, alu;
  logic [32:0] sum;
  logic        ov;
  logic [3:0]  rd;
  logic        setf;
  logic [3:0]  flags_new;

  adpe_pkg::status_t status;
  adpe_pkg::status_t misc_st, ext_st;
  logic [11:0] misc_key;
  logic [4:0]  ext_op;

  assign fn = flags[3];
  assign fz = flags[2];
  assign fc = flags[1];
  assign fv = flags[0];

  // Substitute r15 as instruction address plus 8
  assign pc8  = pc + 32'd8;
  assign rn_v = (instr[19:16] == 4'd15) ? pc8 : ops.rn;
  assign rm_v = (instr[3:0]   == 4'd15) ? pc8 : ops.rm;
  assign rs_v = (instr[11:8]  == 4'd15) ? pc8 : ops.rs;

  // Condition test
  always_comb begin
    case (adpe_pkg::cond_t'(instr[31:28]))
      adpe_pkg::CC_EQ: cond_ok = fz;
      adpe_pkg::CC_NE: cond_ok = !fz;
      adpe_pkg::CC_CS: cond_ok = fc;
      adpe_pkg::CC_CC: cond_ok = !fc;
      adpe_pkg::CC_MI: cond_ok = fn;
      adpe_pkg::CC_PL: cond_ok = !fn;
      adpe_pkg::CC_VS: cond_ok = fv;
      adpe_pkg::CC_VC: cond_ok = !fv;
      adpe_pkg::CC_HI: cond_ok = fc && !fz;
      adpe_pkg::CC_LS: cond_ok = !fc || fz;
      adpe_pkg::CC_GE: cond_ok = (fn == fv);
      adpe_pkg::CC_LT: cond_ok = (fn != fv);
      adpe_pkg::CC_GT: cond_ok = !fz && (fn == fv);
      adpe_pkg::CC_LE: cond_ok = fz || (fn != fv);
      adpe_pkg::CC_AL: cond_ok = 1'b1;
      default:         cond_ok = 1'b0;
    endcase
  end

  // Barrel shifter datapaths
  assign imm_rot = {instr[11:8], 1'b0};
  assign imm_val = ror32({24'd0, instr[7:0]}, imm_rot);
  assign amt     = instr[4] ? rs_v[7:0] : {3'd0, instr[11:7]};
  assign lsl_t   = {1'b0, rm_v} << amt;
  assign lsr_t   = {rm_v, 1'b0} >> amt;
  assign asr_t   = $signed({rm_v, 1'b0}) >>> amt;
  assign ror_v   = ror32(rm_v, amt[4:0]);

  // Select shifter operand and carry
  always_comb begin
    sh = rm_v;
    sc = fc;
    if (instr[25]) begin
      sh = imm_val;
      sc = (imm_rot == 5'd0) ? fc : imm_val[31];
    end else if (amt == 8'd0) begin
      if (instr[4]) begin
        sh = rm_v;
        sc = fc;
      end else begin
        case (adpe_pkg::shift_t'(instr[6:5]))
          adpe_pkg::SH_LSL: begin sh = rm_v;           sc = fc;       end
          adpe_pkg::SH_LSR: begin sh = 32'd0;          sc = rm_v[31]; end
          adpe_pkg::SH_ASR: begin sh = {32{rm_v[31]}}; sc = rm_v[31]; end
          default: begin sh = {fc, rm_v[31:1]}; sc = rm_v[0]; end
        endcase
      end
    end else begin
      case (adpe_pkg::shift_t'(instr[6:5]))
        adpe_pkg::SH_LSL: begin sh = lsl_t[31:0]; sc = lsl_t[32]; end
        adpe_pkg::SH_LSR: begin sh = lsr_t[32:1]; sc = lsr_t[0];  end
        adpe_pkg::SH_ASR: begin sh = asr_t[32:1]; sc = asr_t[0];  end
        default: begin
          if (amt[4:0] == 5'd0) begin
            sh = rm_v;
            sc = rm_v[31];
          end else begin
            sh = ror_v;
            sc = ror_v[31];
          end
        end
      endcase
    end
  end

  // Opcode decode
  assign op = adpe_pkg::opcode_t'(instr[24:21]);
  assign rd = instr[15:12];

  always_comb begin
    kind     = K_LOGIC;
    write_rd = 1'b1;
    impl     = 1'b1;
    a        = rn_v;
    b        = sh;
    lres     = 32'd0;
    case (op)
      adpe_pkg::OP_AND: lres = rn_v & sh;
      adpe_pkg::OP_EOR: lres = rn_v ^ sh;
      adpe_pkg::OP_SUB: kind = K_SUB;
      adpe_pkg::OP_RSB: begin kind = K_SUB; a = sh; b = rn_v; end
      adpe_pkg::OP_ADD: kind = K_ADD;
      adpe_pkg::OP_TST: begin lres = rn_v & sh; write_rd = 1'b0; end
      adpe_pkg::OP_TEQ: begin lres = rn_v ^ sh; write_rd = 1'b0; end
      adpe_pkg::OP_CMP: begin kind = K_SUB; write_rd = 1'b0; end
      adpe_pkg::OP_CMN: begin kind = K_ADD; write_rd = 1'b0; end
      adpe_pkg::OP_ORR: lres = rn_v | sh;
      adpe_pkg::OP_MOV: lres = sh;
      adpe_pkg::OP_BIC: lres = rn_v & ~sh;
      adpe_pkg::OP_MVN: lres = ~sh;
      default:          impl = 1'b0;
    endcase
  end

  // Adder, result and flags
  assign b_eff = (kind == K_SUB) ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {32'd0, (kind == K_SUB)};
  assign alu   = (kind == K_LOGIC) ? lres : sum[31:0];
  assign ov    = ~(a[31] ^ b_eff[31]) & (a[31] ^ sum[31]);
  assign setf  = write_rd ? (instr[20] && (rd != 4'd15)) : 1'b1;

  always_comb begin
    flags_new = flags;
    if (setf) begin
      flags_new[3] = alu[31];
      flags_new[2] = (alu == 32'd0);
      if (kind == K_LOGIC) begin
        flags_new[1] = sc;
      end else begin
        flags_new[1] = sum[32];
        flags_new[0] = ov;
      end
    end
  end

  // Class decode for non-data-processing encodings
  assign misc_key = {instr[27:20], instr[7:4]};
  assign ext_op   = instr[24:20];

  always_comb begin
    if (instr[25]) begin
      misc_st = (instr[27:20] inside {MISC_IMM_MSR_A, MISC_IMM_MSR_B})
                ? adpe_pkg::ST_IGNORED : adpe_pkg::ST_UNIMPL;
    end else begin
      misc_st = (misc_key inside {MISC_BX, MISC_MRS_A, MISC_MRS_B, MISC_MSR_A, MISC_MSR_B})
                ? adpe_pkg::ST_IGNORED : adpe_pkg::ST_UNIMPL;
    end
  end

  always_comb begin
    case (instr[6:5])
      2'd0:    ext_st = (ext_op inside {[5'd0:5'd3], [5'd8:5'd16], 5'd20})
                        ? adpe_pkg::ST_IGNORED : adpe_pkg::ST_UNIMPL;
      2'd1:    ext_st = adpe_pkg::ST_IGNORED;
      default: ext_st = instr[20] ? adpe_pkg::ST_IGNORED : adpe_pkg::ST_UNIMPL;
    endcase
  end

  always_comb begin
    if (adpe_pkg::cond_t'(instr[31:28]) == adpe_pkg::CC_NV) begin
      status = adpe_pkg::ST_UNDEF_NV;
    end else if (!cond_ok) begin
      status = adpe_pkg::ST_COND_FAIL;
    end else if (instr[27:26] != 2'd0) begin
      status = adpe_pkg::ST_IGNORED;
    end else if ((instr & adpe_pkg::MISC_MASK) == adpe_pkg::MISC_MATCH) begin
      status = misc_st;
    end else if ((instr & adpe_pkg::EXT_MASK) == adpe_pkg::EXT_MATCH) begin
      status = ext_st;
    end else if (!impl) begin
      status = adpe_pkg::ST_UNIMPL;
    end else begin
      status = adpe_pkg::ST_EXECUTED;
    end
  end

  // Assemble the result beat
  always_comb begin
    res.status  = status;
    res.wrote   = 1'b0;
    res.idx     = 4'd0;
    res.val     = 32'd0;
    res.flags   = flags;
    res.next_pc = pc + 32'd4;
    if (status == adpe_pkg::ST_EXECUTED) begin
      res.flags = flags_new;
      if (write_rd) begin
        res.wrote = 1'b1;
        res.idx   = rd;
        res.val   = alu;
        if (rd == 4'd15) begin
          res.next_pc = alu;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/arm_data_processing_execute.sv =====
// ARM data-processing execute block: one instruction word in, one result beat out.
// The accepted beat is registered in s1_instr, and its result in the output register.
// Throughput: one instruction per cycle while the output does not stall; register operands
// are read as the beat is accepted, with a bypass from the instruction executing at that edge.
// Reset (rst, synchronous): r0..r14 and NZCV read as zero, pc is zero, both stages empty.
// Depends on adpe_pkg, adpe_regfile and adpe_exec.
`default_nettype none

module arm_data_processing_execute (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // instr[31:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // status[2:0], dest_written[3], dest_index[7:4],
                                      // dest_value[39:8], flags_nzcv[43:40],
                                      // next_pc[75:44], zero[79:76]
);

  logic                 s1_valid;
  logic [31:0]          s1_instr;
  logic                 s1_fire;
  logic                 accept;
  logic [31:0]          pc;
  logic [3:0]           flags;
  adpe_pkg::operands_t  ops;
  adpe_pkg::rf_wr_t     rf_wr;
  adpe_pkg::exec_res_t  res;
  adpe_pkg::exec_res_t  out_res;

  // Handshake between stages
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;

  // Register writes from the executing instruction; r15 lives in pc
  assign rf_wr.we    = s1_fire && res.wrote && (res.idx != 4'd15);
  assign rf_wr.waddr = res.idx;
  assign rf_wr.wdata = res.val;

  adpe_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .raddr_n (s_tdata[19:16]),
    .raddr_m (s_tdata[3:0]),
    .raddr_s (s_tdata[11:8]),
    .wr      (rf_wr),
    .ops     (ops)
  );

  adpe_exec u_exec (
    .instr (s1_instr),
    .ops   (ops),
    .pc    (pc),
    .flags (flags),
    .res   (res)
  );

  // Capture the instruction beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= s_tdata;
    end
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= 32'd0;
      flags <= 4'd0;
    end else if (s1_fire) begin
      pc    <= res.next_pc;
      flags <= res.flags;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res.next_pc, out_res.flags, out_res.val, out_res.idx,
                    out_res.wrote, out_res.status};

  // An executing instruction always lands in the output register
  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("executed instruction did not reach output register");

  // An empty input stage must take a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled while empty");

  // Only executed instructions write a destination
  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.wrote |-> out_res.status == adpe_pkg::ST_EXECUTED)
    else $error("destination written by non-executed instruction");

  // No write leaves index and value at zero
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.wrote |-> out_res.idx == 4'd0 && out_res.val == 32'd0)
    else $error("stray destination fields");

  // PC advances by 4 unless r15 is the destination
  a_pc_step: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !(res.wrote && res.idx == 4'd15) |=> pc == $past(pc) + 32'd4)
    else $error("pc did not advance by 4");

endmodule

`default_nettype wire
